// File: hdl/smar_pkg.sv
// ----------------------------------------------------------------------------
// Six-axis moving average package
// Shared constants, types and coefficient codes for the filter and remap.
// ----------------------------------------------------------------------------
package smar_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int NUM_AXES     = 6;
    localparam int MAP_BITS     = 18;
    localparam int OUT_BITS     = 18;

    localparam logic [MAP_BITS-1:0] AXIS_MAP_RESET = 18'd65608;

    localparam int DEPTH_LOG    = $clog2(WINDOW_DEPTH);
    localparam int FILL_BITS    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS     = SAMPLE_BITS + DEPTH_LOG;
    localparam int AVG_BITS     = SAMPLE_BITS + 1;
    localparam int DIV_SHIFT    = SUM_BITS + DEPTH_LOG;
    localparam int RECIP_BITS   = SUM_BITS + 1;
    localparam int PROD_BITS    = SUM_BITS + RECIP_BITS;
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [AVG_BITS-1:0]    avg_t;
    typedef logic signed [OUT_BITS-1:0]    out_t;

    typedef enum logic [1:0] {
        COEF_ZERO   = 2'd0,
        COEF_PLUS   = 2'd1,
        COEF_MINUS  = 2'd2,
        COEF_UNUSED = 2'd3
    } coef_code_t;

    typedef struct packed {
        logic load;
        logic running;
        logic en_b;
        logic en_c;
    } lane_ctl_t;

endpackage

// File: hdl/smar_if.sv
// ----------------------------------------------------------------------------
// Six-axis moving average channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface smar_sample_if
    import smar_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t in_acc_x;
    sample_t in_acc_y;
    sample_t in_acc_z;
    sample_t in_rate_x;
    sample_t in_rate_y;
    sample_t in_rate_z;

    modport source (output valid, in_acc_x, in_acc_y, in_acc_z,
                    in_rate_x, in_rate_y, in_rate_z, input ready);
    modport sink (input valid, in_acc_x, in_acc_y, in_acc_z,
                  in_rate_x, in_rate_y, in_rate_z, output ready);
endinterface

interface smar_result_if
    import smar_pkg::*;
();
    logic valid;
    logic ready;
    out_t avg_acc_x;
    out_t avg_acc_y;
    out_t avg_acc_z;
    out_t avg_rate_x;
    out_t avg_rate_y;
    out_t avg_rate_z;

    modport source (output valid, avg_acc_x, avg_acc_y, avg_acc_z,
                    avg_rate_x, avg_rate_y, avg_rate_z, input ready);
    modport sink (input valid, avg_acc_x, avg_acc_y, avg_acc_z,
                  avg_rate_x, avg_rate_y, avg_rate_z, output ready);
endinterface

interface smar_cfg_if
    import smar_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MAP_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: hdl/smar_lane.sv
// ----------------------------------------------------------------------------
// Six-axis moving average lane
// Sample history, running sum and divide by the window depth for one axis.
// ----------------------------------------------------------------------------
module smar_lane
    import smar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  lane_ctl_t ctl,
    input  sample_t   sample,
    output avg_t      avg
);

    sample_t                    line_reg [WINDOW_DEPTH];
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [SUM_BITS-1:0] oldest;
    logic [SUM_BITS-1:0]        mag;
    logic [PROD_BITS-1:0]       prod_reg;
    logic [PROD_BITS-1:0]       prod_next;
    logic                       neg_reg;
    logic [AVG_BITS-1:0]        quot;
    avg_t                       avg_reg;
    avg_t                       avg_next;

    always_comb
    begin
        oldest   = ctl.running ? SUM_BITS'(line_reg[WINDOW_DEPTH-1]) : '0;
        sum_next = sum_reg + SUM_BITS'(sample) - oldest;
        mag      = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
        prod_next = PROD_BITS'(mag) * PROD_BITS'(DIV_RECIP);
        quot     = prod_reg[DIV_SHIFT +: AVG_BITS];
        avg_next = neg_reg ? avg_t'(-quot) : avg_t'(quot);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            line_reg[0] <= sample;
            for (int i = 1; i < WINDOW_DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctl.load)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_b)
        begin
            prod_reg <= prod_next;
            neg_reg  <= sum_reg[SUM_BITS-1];
        end
        if (ctl.en_c)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

// File: hdl/smar_remap.sv
// ----------------------------------------------------------------------------
// Six-axis moving average remap
// Merges the six lane averages through the mounting matrix into the result.
// ----------------------------------------------------------------------------
module smar_remap
    import smar_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [MAP_BITS-1:0] axis_map,
    input  avg_t                avg [NUM_AXES],
    output out_t                res [NUM_AXES]
);

    out_t res_reg  [NUM_AXES];
    out_t res_next [NUM_AXES];

    function automatic out_t coef_term(input coef_code_t code, input avg_t value);
        out_t ext;
        ext = OUT_BITS'(value);
        case (code)
            COEF_PLUS:  return ext;
            COEF_MINUS: return -ext;
            default:    return '0;
        endcase
    endfunction

    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                res_next[3*g+r] =
                    coef_term(coef_code_t'(axis_map[2*(3*r)   +: 2]), avg[3*g])
                  + coef_term(coef_code_t'(axis_map[2*(3*r+1) +: 2]), avg[3*g+1])
                  + coef_term(coef_code_t'(axis_map[2*(3*r+2) +: 2]), avg[3*g+2]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: hdl/six_axis_moving_average_remap_top.sv
// ----------------------------------------------------------------------------
// Six-axis moving average with axis remap
// Boxcar average over a window of samples per axis, remapped by a matrix.
//
// The samples channel carries one six-axis reading per transaction. The
// first WINDOW_DEPTH transactions after reset only fill the window and give
// no result. Every later sample gives one transaction on the results channel
// with the six window averages, truncated toward zero and remapped by the
// axis_map matrix. The cfg channel writes axis_map; it is always ready.
// After a sample is accepted, its result is registered in turn: the running
// sum is registered at the accepting edge, and the reciprocal multiply, the
// quotient and the remap each add one registered stage.
// The block accepts one sample every cycle while results are taken. When the receiver stalls, the
// stages fill up one by one and samples keep flowing until they are full.
// Reset clears the sums, the fill count and the stage valid flags, and sets
// axis_map to its default; the window history needs no clearing because it
// is fully written during the fill phase.
// ----------------------------------------------------------------------------
module six_axis_moving_average_remap_top
    import smar_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    smar_sample_if.sink   samples,
    smar_result_if.source results,
    smar_cfg_if.sink      cfg
);

    logic [MAP_BITS-1:0]  axis_map_reg;
    logic [FILL_BITS-1:0] fill_cnt_reg;
    logic                 running_reg;
    logic                 a_valid_reg;
    logic                 b_valid_reg;
    logic                 c_valid_reg;
    logic                 out_valid_reg;
    logic                 out_free;
    logic                 ready_c;
    logic                 ready_b;
    logic                 ready_a;
    logic                 accept;
    lane_ctl_t            ctl;
    sample_t              lane_in  [NUM_AXES];
    avg_t                 lane_avg [NUM_AXES];
    out_t                 res      [NUM_AXES];

    assign out_free = !out_valid_reg || results.ready;
    assign ready_c  = !c_valid_reg || out_free;
    assign ready_b  = !b_valid_reg || ready_c;
    assign ready_a  = !a_valid_reg || ready_b;
    assign accept   = samples.valid && ready_a;

    assign samples.ready = ready_a;
    assign cfg.ready     = 1'b1;

    assign ctl.load    = accept;
    assign ctl.running = running_reg;
    assign ctl.en_b    = ready_b;
    assign ctl.en_c    = ready_c;

    assign lane_in[0] = samples.in_acc_x;
    assign lane_in[1] = samples.in_acc_y;
    assign lane_in[2] = samples.in_acc_z;
    assign lane_in[3] = samples.in_rate_x;
    assign lane_in[4] = samples.in_rate_y;
    assign lane_in[5] = samples.in_rate_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_map_reg  <= AXIS_MAP_RESET;
            fill_cnt_reg  <= '0;
            running_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                axis_map_reg <= cfg.data;
            end
            if (accept && !running_reg)
            begin
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
                running_reg  <= (fill_cnt_reg == FILL_BITS'(WINDOW_DEPTH - 1));
            end
            if (ready_a)
            begin
                a_valid_reg <= accept && running_reg;
            end
            if (ready_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (ready_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        smar_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sample (lane_in[g]),
            .avg    (lane_avg[g])
        );
    end

    smar_remap u_remap (
        .clk      (clk),
        .en       (out_free),
        .axis_map (axis_map_reg),
        .avg      (lane_avg),
        .res      (res)
    );

    assign results.valid      = out_valid_reg;
    assign results.avg_acc_x  = res[0];
    assign results.avg_acc_y  = res[1];
    assign results.avg_acc_z  = res[2];
    assign results.avg_rate_x = res[3];
    assign results.avg_rate_y = res[4];
    assign results.avg_rate_z = res[5];

    // A sample taken during the fill phase must never start a result.
    a_fill_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !running_reg) |=> !a_valid_reg)
        else $error("fill-phase sample produced a result");

    // The fill count stops at the window depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= FILL_BITS'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    // Once the window is full the block stays in the running phase.
    a_running_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |=> running_reg)
        else $error("running phase left without reset");

    // Input back-pressure only arises from a full pipeline.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (a_valid_reg && b_valid_reg && c_valid_reg
                            && out_valid_reg && !results.ready))
        else $error("input stalled with room in the pipeline");

endmodule

// File: tb/six_axis_moving_average_remap_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Six-axis moving average with axis remap testbench
// Drives six-axis samples through a short directed table and then through
// random phases, each of which writes an axis_map setting. Every accepted sample
// is run through a window predictor in this file, and every result
// transaction is compared field by field with the oldest expected average.
// Both channel sides idle at random, and the result side is held off for
// long stretches so that the block fills up and stalls its sample input.
// ----------------------------------------------------------------------------
module six_axis_moving_average_remap_top_test;
    import smar_pkg::*;

    typedef struct packed {
        sample_t acc_x;
        sample_t acc_y;
        sample_t acc_z;
        sample_t rate_x;
        sample_t rate_y;
        sample_t rate_z;
    } reading_t;

    typedef struct packed {
        out_t acc_x;
        out_t acc_y;
        out_t acc_z;
        out_t rate_x;
        out_t rate_y;
        out_t rate_z;
    } averages_t;

    typedef struct packed {
        logic [4:0] reps;
        reading_t   smp;
        logic       typed;
        averages_t  want;
    } stim_row_t;

    typedef enum int {
        MIX_ANY,
        MIX_HIGH_RAIL,
        MIX_LOW_RAIL
    } sample_mix_t;

    localparam int DIRECTED_ROWS = 10;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 188;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 64;
    localparam int HOLD_SPACING  = 450;

    localparam logic [MAP_BITS-1:0] MAP_ALL_ZERO   = 18'h00000;
    localparam logic [MAP_BITS-1:0] MAP_ALL_UNUSED = 18'h3FFFF;
    localparam logic [MAP_BITS-1:0] MAP_ALL_PLUS   = 18'h15555;
    localparam logic [MAP_BITS-1:0] MAP_ALL_MINUS  = 18'h2AAAA;
    localparam logic [MAP_BITS-1:0] MAP_IDENTITY   = 18'h10101;

    // With the default map, output x is minus input y, y is x and z is z.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{5'd16, '{32767, -32768, -1, -32768, 32767, 1}, 1'b0, '0},
        '{5'd1, '{32767, -32768, -1, -32768, 32767, 1}, 1'b1,
          '{32768, 32767, -1, -32767, -32768, 1}},
        '{5'd1, '{32767, -32768, 0, -32768, 32767, 0}, 1'b1,
          '{32768, 32767, 0, -32767, -32768, 0}},
        '{5'd1, '{0, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{5'd1, '{1, -1, 21845, -21846, 2, -2}, 1'b0, '0},
        '{5'd1, '{-32768, 32767, -32768, 32767, -32768, 32767}, 1'b0, '0},
        '{5'd1, '{32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, '0},
        '{5'd1, '{-32768, -32768, -32768, -32768, -32768, -32768}, 1'b0, '0},
        '{5'd1, '{4660, -4660, 7, -7, 100, -100}, 1'b0, '0},
        '{5'd1, '{-1, -1, -1, -1, -1, -1}, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    smar_sample_if samples();
    smar_result_if results();
    smar_cfg_if    cfg();

    six_axis_moving_average_remap_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results),
        .cfg     (cfg)
    );

    int                  window_hist [WINDOW_DEPTH][NUM_AXES];
    int                  axis_sum [NUM_AXES] = '{default: 0};
    int                  fill_pos = 0;
    bit                  window_full = 1'b0;
    logic [MAP_BITS-1:0] map_model = AXIS_MAP_RESET;

    averages_t expected_averages [$];

    int samples_sent = 0;
    int results_seen = 0;
    int map_writes   = 0;
    int mismatches   = 0;
    int next_long_hold = 24;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("six_axis_moving_average_remap_top_test failed");
        $finish;
    end

    function automatic int axis_coef(int k);
        coef_code_t code;
        code = coef_code_t'(map_model[2*k +: 2]);
        case (code)
            COEF_PLUS:  return 1;
            COEF_MINUS: return -1;
            default:    return 0;
        endcase
    endfunction

    task automatic advance_window(input reading_t smp, output bit produced,
                                  output averages_t avg_out);
        int s [NUM_AXES];
        int avg [NUM_AXES];
        int mapped [NUM_AXES];
        int acc;
        s = '{smp.acc_x, smp.acc_y, smp.acc_z, smp.rate_x, smp.rate_y, smp.rate_z};
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (window_full)
                axis_sum[a] -= window_hist[fill_pos][a];
            window_hist[fill_pos][a] = s[a];
            axis_sum[a] += s[a];
        end
        fill_pos = (fill_pos + 1) % WINDOW_DEPTH;
        produced = window_full;
        avg_out = '0;
        if (!window_full)
        begin
            if (fill_pos == 0)
                window_full = 1'b1;
        end
        else
        begin
            for (int a = 0; a < NUM_AXES; a++)
                avg[a] = axis_sum[a] / WINDOW_DEPTH;
            for (int g = 0; g < 2; g++)
                for (int r = 0; r < 3; r++)
                begin
                    acc = 0;
                    for (int c = 0; c < 3; c++)
                        acc += axis_coef(3*r + c) * avg[3*g + c];
                    mapped[3*g + r] = acc;
                end
            avg_out = '{out_t'(mapped[0]), out_t'(mapped[1]), out_t'(mapped[2]),
                        out_t'(mapped[3]), out_t'(mapped[4]), out_t'(mapped[5])};
        end
    endtask

    function automatic int draw_gap(bit quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55)
            return 0;
        else if (pick < 88)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int draw_axis();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            2, 3:    return int'($urandom_range(0, 8)) - 4;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic reading_t draw_reading(sample_mix_t mix);
        int v [NUM_AXES];
        bit rail;
        rail = ($urandom_range(0, 15) != 0);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            v[a] = draw_axis();
            if (rail && mix == MIX_HIGH_RAIL)
                v[a] = 32767;
            else if (rail && mix == MIX_LOW_RAIL)
                v[a] = -32768;
        end
        return '{sample_t'(v[0]), sample_t'(v[1]), sample_t'(v[2]),
                 sample_t'(v[3]), sample_t'(v[4]), sample_t'(v[5])};
    endfunction

    task automatic send_sample(input reading_t smp, input bit use_want,
                               input averages_t want);
        int gap;
        bit produced;
        averages_t predicted;
        gap = draw_gap(tx_quiet);
        if (gap > 0)
        begin
            @(negedge clk);
            samples.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samples.valid     <= 1'b1;
        samples.in_acc_x  <= smp.acc_x;
        samples.in_acc_y  <= smp.acc_y;
        samples.in_acc_z  <= smp.acc_z;
        samples.in_rate_x <= smp.rate_x;
        samples.in_rate_y <= smp.rate_y;
        samples.in_rate_z <= smp.rate_z;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        samples_sent++;
        advance_window(smp, produced, predicted);
        if (produced)
            expected_averages.push_back(use_want ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        samples.valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_axis_map(input logic [MAP_BITS-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        map_model = value;
        map_writes++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic check_axis(input string name, input out_t want, input out_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            results_seen++;
            if (expected_averages.size() == 0)
            begin
                $error("result transaction with no expected average pending");
                mismatches++;
            end
            else
            begin
                check_axis("avg_acc_x", expected_averages[0].acc_x, results.avg_acc_x);
                check_axis("avg_acc_y", expected_averages[0].acc_y, results.avg_acc_y);
                check_axis("avg_acc_z", expected_averages[0].acc_z, results.avg_acc_z);
                check_axis("avg_rate_x", expected_averages[0].rate_x, results.avg_rate_x);
                check_axis("avg_rate_y", expected_averages[0].rate_y, results.avg_rate_y);
                check_axis("avg_rate_z", expected_averages[0].rate_z, results.avg_rate_z);
                void'(expected_averages.pop_front());
            end
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (results_seen >= next_long_hold)
                begin
                    hold = LONG_HOLD;
                    next_long_hold += HOLD_SPACING;
                end
                else
                    hold = draw_gap(rx_quiet);
            end
            if (hold > 0)
            begin
                results.ready <= 1'b0;
                hold--;
            end
            else
                results.ready <= 1'b1;
        end
    end

    initial
    begin
        logic [MAP_BITS-1:0] phase_map;
        sample_mix_t         phase_mix;
        rst_n             = 1'b0;
        samples.valid     = 1'b0;
        samples.in_acc_x  = '0;
        samples.in_acc_y  = '0;
        samples.in_acc_z  = '0;
        samples.in_rate_x = '0;
        samples.in_rate_y = '0;
        samples.in_rate_z = '0;
        cfg.valid         = 1'b0;
        cfg.data          = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++)
            for (int rep = 0; rep < directed_rows[row].reps; rep++)
                send_sample(directed_rows[row].smp, directed_rows[row].typed,
                            directed_rows[row].want);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            phase_mix = MIX_ANY;
            case (phase)
                0: phase_map = MAP_ALL_ZERO;
                1: phase_map = MAP_ALL_UNUSED;
                2: begin phase_map = MAP_ALL_PLUS;  phase_mix = MIX_HIGH_RAIL; end
                3: begin phase_map = MAP_ALL_MINUS; phase_mix = MIX_LOW_RAIL;  end
                4: phase_map = MAP_IDENTITY;
                5: phase_map = AXIS_MAP_RESET;
                6: begin phase_map = MAP_ALL_PLUS;  phase_mix = MIX_LOW_RAIL;  end
                7: begin phase_map = MAP_ALL_MINUS; phase_mix = MIX_HIGH_RAIL; end
                default: phase_map = MAP_BITS'($urandom_range(0, 262143));
            endcase
            tx_quiet = (phase % 4 == 1);
            rx_quiet = (phase % 4 == 1);
            write_axis_map(phase_map);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(draw_reading(phase_mix), 1'b0, '0);
            drain_results();
        end

        $display("Sent %0d samples and checked %0d averaged results over %0d axis maps.",
                 samples_sent, results_seen, map_writes);
        $display("Phases covered zero, unused, full-scale and random maps with output stalls.");
        if (mismatches == 0)
            $display("six_axis_moving_average_remap_top_test passed");
        else
            $display("six_axis_moving_average_remap_top_test failed");
        $finish;
    end

endmodule
